// File: design/wide_float_to_fp32_convert_core_macros.svh
// assertion macros for the converter rtl
// expects clk and rst in the scope of each use
`ifndef WIDE_FLOAT_TO_FP32_CONVERT_CORE_MACROS_SVH
`define WIDE_FLOAT_TO_FP32_CONVERT_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WFP32_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WFP32_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wfp32_pkg.sv
// shared types and constants for the wide float to binary32 converter
// no dependencies
package wfp32_pkg;

  localparam int unsigned SRC_EXP_W  = 32;
  localparam int unsigned SRC_FRAC_W = 31;
  localparam int unsigned FP32_W     = 32;
  localparam int unsigned CLS_W      = 3;

  // value class codes for source and result
  typedef enum logic [CLS_W-1:0] {
    CLS_ZERO = 3'd0,
    CLS_SUB  = 3'd1,
    CLS_NORM = 3'd2,
    CLS_INF  = 3'd3,
    CLS_NAN  = 3'd4
  } cls_t;

  // source exponent thresholds (bias 2^31-1)
  localparam logic [SRC_EXP_W-1:0] SRC_EXP_ZERO     = 32'h0000_0000;
  localparam logic [SRC_EXP_W-1:0] SRC_EXP_ALL_ONES = 32'hFFFF_FFFF;
  // true exponent 128 and up
  localparam logic [SRC_EXP_W-1:0] OVF_EXP_MIN      = 32'h8000_007F;
  // true exponent -126 and up
  localparam logic [SRC_EXP_W-1:0] NORM_EXP_MIN     = 32'h7FFF_FF81;
  // below this the subnormal shift reaches 32 or more
  localparam logic [SRC_EXP_W-1:0] SUB_NEAR_MIN     = 32'h7FFF_FF6A;

  // low-byte offsets: exp field = ex - 0x7fffff80, shift = 0x7fffff89 - ex
  localparam logic [7:0] NORM_EXP_OFFSET = 8'h80;
  localparam logic [7:0] SUB_SHIFT_LOW   = 8'h89;

  localparam logic [7:0] FP32_EXP_MAX = 8'hFF;
  localparam logic [7:0] FP32_EXP_MIN = 8'h01;

  // decode of one source operand
  typedef struct packed {
    cls_t src_cls;
    logic overflow;
    logic norm_range;
    logic deep_sub;
  } src_info_t;

endpackage

// File: design/wfp32_in_if.sv
// operand channel: valid/ready plus source float fields
// depends on nothing
interface wfp32_in_if;
  logic        valid;
  logic        ready;
  logic        sign_bit;
  logic [31:0] exponent_field;
  logic [30:0] fraction_field;

  modport source (output valid, sign_bit, exponent_field, fraction_field, input ready);
  modport sink   (input valid, sign_bit, exponent_field, fraction_field, output ready);
endinterface

// File: design/wfp32_out_if.sv
// result channel: valid/ready plus binary32 word and class codes
// depends on nothing
interface wfp32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] single_word;
  logic [2:0]  source_class;
  logic [2:0]  result_class;

  modport source (output valid, single_word, source_class, result_class, input ready);
  modport sink   (input valid, single_word, source_class, result_class, output ready);
endinterface

// File: design/wfp32_classify.sv
// source operand decode: class and exponent range flags
// depends on wfp32_pkg
module wfp32_classify
  import wfp32_pkg::*;
(
  input  logic [SRC_EXP_W-1:0]  exponent_field,
  input  logic [SRC_FRAC_W-1:0] fraction_field,
  output src_info_t             info
);

  logic frac_zero;

  assign frac_zero = (fraction_field == '0);

  // class from the reserved exponent codes, range of a normal source against binary32
  always_comb begin
    if (exponent_field == SRC_EXP_ZERO) begin
      info.src_cls = frac_zero ? CLS_ZERO : CLS_SUB;
    end else if (exponent_field == SRC_EXP_ALL_ONES) begin
      info.src_cls = frac_zero ? CLS_INF : CLS_NAN;
    end else begin
      info.src_cls = CLS_NORM;
    end
    info.overflow   = (exponent_field >= OVF_EXP_MIN);
    info.norm_range = (exponent_field >= NORM_EXP_MIN);
    info.deep_sub   = (exponent_field <  SUB_NEAR_MIN);
  end

endmodule

// File: design/wfp32_pack.sv
// rounding and binary32 packing for one decoded operand
// depends on wfp32_pkg
module wfp32_pack
  import wfp32_pkg::*;
(
  input  logic                  sign_bit,
  input  logic [SRC_EXP_W-1:0]  exponent_field,
  input  logic [SRC_FRAC_W-1:0] fraction_field,
  input  src_info_t             info,
  output logic [FP32_W-1:0]     single_word,
  output cls_t                  result_class
);

  logic [31:0] sig;
  logic [24:0] norm_m;
  logic [8:0]  norm_exp;
  logic        norm_ovf;
  logic [4:0]  sub_sh;
  logic [31:0] sub_shifted;
  logic [31:0] sub_mask;
  logic        sub_sticky;
  logic [23:0] sub_m;
  logic [23:0] sub_r;
  logic [22:0] nan_pay;

  assign sig = {1'b1, fraction_field};

  // normal range: drop 8 bits, round up on any nonzero dropped bit
  assign norm_m   = {1'b0, sig[31:8]} + 25'(|fraction_field[7:0]);
  assign norm_exp = {1'b0, exponent_field[7:0] - NORM_EXP_OFFSET} + 9'(norm_m[24]);
  assign norm_ovf = (norm_exp >= {1'b0, FP32_EXP_MAX});

  // subnormal range: right shift of 9 to 31, sticky from the lost bits
  assign sub_sh      = 5'(SUB_SHIFT_LOW - exponent_field[7:0]);
  assign sub_shifted = sig >> sub_sh;
  assign sub_mask    = (32'h1 << sub_sh) - 32'h1;
  assign sub_sticky  = info.deep_sub | (|(sig & sub_mask));
  assign sub_m       = info.deep_sub ? 24'h0 : sub_shifted[23:0];
  assign sub_r       = sub_m + 24'(sub_sticky);

  // nan payload keeps the top fraction bits, never all zero
  assign nan_pay = (fraction_field[30:8] == '0) ? 23'h1 : fraction_field[30:8];

  // result selection by source class
  always_comb begin
    case (info.src_cls)
      CLS_ZERO: begin
        single_word  = {sign_bit, 31'h0};
        result_class = CLS_ZERO;
      end
      CLS_SUB: begin
        single_word  = {sign_bit, 31'h1};
        result_class = CLS_SUB;
      end
      CLS_INF: begin
        single_word  = {sign_bit, FP32_EXP_MAX, 23'h0};
        result_class = CLS_INF;
      end
      CLS_NAN: begin
        single_word  = {sign_bit, FP32_EXP_MAX, nan_pay};
        result_class = CLS_NAN;
      end
      CLS_NORM: begin
        if (info.overflow || (info.norm_range && norm_ovf)) begin
          single_word  = {sign_bit, FP32_EXP_MAX, 23'h0};
          result_class = CLS_INF;
        end else if (info.norm_range) begin
          single_word  = {sign_bit, norm_exp[7:0], norm_m[22:0]};
          result_class = CLS_NORM;
        end else if (sub_r[23]) begin
          single_word  = {sign_bit, FP32_EXP_MIN, 23'h0};
          result_class = CLS_NORM;
        end else begin
          single_word  = {sign_bit, 8'h00, sub_r[22:0]};
          result_class = CLS_SUB;
        end
      end
      default: begin
        single_word  = {sign_bit, 31'h0};
        result_class = CLS_ZERO;
      end
    endcase
  end

endmodule

// File: design/wide_float_to_fp32_convert_core.sv
// an operand beat passes the input register and then the result register to its result beat
// throughput: one beat per cycle; under a result stall the result register holds and
// the input register takes one more operand only if it is empty
// reset (synchronous, active high) clears both valid flags; payload is not reset
// uses wfp32_pkg, wfp32_in_if, wfp32_out_if, wfp32_classify, wfp32_pack
`include "wide_float_to_fp32_convert_core_macros.svh"

module wide_float_to_fp32_convert_core
  import wfp32_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wfp32_in_if.sink    operand,
  wfp32_out_if.source result
);

  logic                  s1_valid;
  logic                  s1_sign;
  logic [SRC_EXP_W-1:0]  s1_exp;
  logic [SRC_FRAC_W-1:0] s1_frac;
  logic                  out_valid;
  logic [FP32_W-1:0]     out_word;
  cls_t                  out_src_cls;
  cls_t                  out_res_cls;
  logic                  s2_ready;
  logic                  in_ready;
  src_info_t             info;
  logic [FP32_W-1:0]     word_next;
  cls_t                  res_cls_next;

  // handshake: each register advances when empty or draining
  assign s2_ready      = !out_valid || result.ready;
  assign in_ready      = !s1_valid || s2_ready;
  assign operand.ready = in_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= operand.valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (operand.valid && in_ready) begin
      s1_sign <= operand.sign_bit;
      s1_exp  <= operand.exponent_field;
      s1_frac <= operand.fraction_field;
    end
  end

  // decode and convert
  wfp32_classify u_classify (
    .exponent_field (s1_exp),
    .fraction_field (s1_frac),
    .info           (info)
  );

  wfp32_pack u_pack (
    .sign_bit       (s1_sign),
    .exponent_field (s1_exp),
    .fraction_field (s1_frac),
    .info           (info),
    .single_word    (word_next),
    .result_class   (res_cls_next)
  );

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      out_word    <= word_next;
      out_src_cls <= info.src_cls;
      out_res_cls <= res_cls_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.single_word  = out_word;
  assign result.source_class = out_src_cls;
  assign result.result_class = out_res_cls;

  // checks
  `WFP32_ASSERT_NEXT(a_stage_moves, (s1_valid && s2_ready), out_valid, "beat lost between stages")
  `WFP32_ASSERT_SAME(a_stall_chain, !in_ready, (s1_valid && out_valid && !result.ready), "operand stalled without full pipe")
  `WFP32_ASSERT_SAME(a_inf_word, (out_valid && out_res_cls == CLS_INF), (out_word[30:0] == {FP32_EXP_MAX, 23'h0}), "infinity class with wrong encoding")
  `WFP32_ASSERT_SAME(a_nan_kept, (out_valid && out_src_cls == CLS_NAN), (out_res_cls == CLS_NAN && out_word[22:0] != 23'h0), "nan source not mapped to nan")
  `WFP32_ASSERT_SAME(a_zero_kept, (out_valid && out_src_cls == CLS_ZERO), (out_res_cls == CLS_ZERO && out_word[30:0] == 31'h0), "zero source not mapped to zero")

endmodule

// File: dv/testbench.sv
// self-checking testbench for wide_float_to_fp32_convert_core
// depends on wfp32_pkg, wfp32_in_if, wfp32_out_if and the core rtl
module testbench;
  import wfp32_pkg::*;

  localparam longint      SRC_BIAS_VAL = 64'sd2147483647;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 150;

  // expected binary32 word plus class codes for one operand
  typedef struct packed {
    logic [31:0] word;
    cls_t        src_cls;
    cls_t        res_cls;
  } fp32_expect_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_pattern_e;

  logic clk;
  logic rst;

  wfp32_in_if  operand_bus ();
  wfp32_out_if result_bus ();

  wide_float_to_fp32_convert_core dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_bus),
    .result  (result_bus)
  );

  fp32_expect_t pending_conversions[$];
  int unsigned  mismatch_count  = 0;
  int unsigned  cycle_count     = 0;
  int unsigned  burst_left      = 0;
  int unsigned  hold_off_cycles = 0;

  // biased source exponent for a true exponent
  function automatic logic [31:0] src_exp(input int true_exp);
    return 32'(SRC_BIAS_VAL + true_exp);
  endfunction

  // narrowing conversion with round-away-from-zero on any dropped bit
  function automatic fp32_expect_t narrow_to_fp32(input logic sgn, input logic [31:0] ex,
                                                  input logic [30:0] fr);
    fp32_expect_t res;
    logic [31:0]  sign_word;
    logic [31:0]  sig;
    logic [24:0]  mant;
    logic [31:0]  sub_mant;
    logic [22:0]  payload;
    logic         sticky;
    longint       e;
    longint       sh;
    sign_word = {sgn, 31'd0};
    sig       = {1'b1, fr};
    if (ex == SRC_EXP_ZERO) begin
      if (fr == '0) begin
        res = '{sign_word, CLS_ZERO, CLS_ZERO};
      end else begin
        // far below range, nonzero fraction rounds up to the smallest subnormal
        res = '{sign_word | 32'd1, CLS_SUB, CLS_SUB};
      end
    end else if (ex == SRC_EXP_ALL_ONES) begin
      if (fr == '0) begin
        res = '{sign_word | 32'h7F80_0000, CLS_INF, CLS_INF};
      end else begin
        payload = fr[30:8];
        if (payload == '0) payload = 23'd1;
        res = '{sign_word | 32'h7F80_0000 | {9'd0, payload}, CLS_NAN, CLS_NAN};
      end
    end else begin
      e = longint'({32'd0, ex}) - SRC_BIAS_VAL;
      res.src_cls = CLS_NORM;
      if (e > 127) begin
        res.word    = sign_word | 32'h7F80_0000;
        res.res_cls = CLS_INF;
      end else if (e >= -126) begin
        mant = {1'b0, sig[31:8]};
        if (sig[7:0] != '0) mant = mant + 25'd1;
        // rounding carry out of the significand bumps the exponent
        if (mant == 25'h100_0000) begin
          mant = 25'h80_0000;
          e    = e + 1;
        end
        if (e > 127) begin
          res.word    = sign_word | 32'h7F80_0000;
          res.res_cls = CLS_INF;
        end else begin
          res.word    = sign_word | {1'b0, 8'(e + 127), mant[22:0]};
          res.res_cls = CLS_NORM;
        end
      end else begin
        // subnormal, all shifted-out bits feed sticky
        sh = -e - 118;
        if (sh >= 32) begin
          sub_mant = '0;
          sticky   = 1'b1;
        end else begin
          sub_mant = sig >> int'(sh);
          sticky   = (sig & ((32'd1 << int'(sh)) - 32'd1)) != '0;
        end
        if (sticky) sub_mant = sub_mant + 32'd1;
        if (sub_mant >= 32'h0080_0000) begin
          res.word    = sign_word | 32'h0080_0000;
          res.res_cls = CLS_NORM;
        end else begin
          res.word    = sign_word | sub_mant;
          res.res_cls = CLS_SUB;
        end
      end
    end
    return res;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wide_float_to_fp32_convert_core regression: fail");
      $finish;
    end
  end

  // result check first, then record the operand beat of this edge
  always @(posedge clk) begin
    fp32_expect_t want;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_conversions.size() == 0) begin
          $error("result beat with no pending conversion: single_word %h",
                 result_bus.single_word);
          mismatch_count++;
        end else begin
          want = pending_conversions.pop_front();
          if (result_bus.single_word !== want.word) begin
            $error("single_word: expected %h, actual %h", want.word, result_bus.single_word);
            mismatch_count++;
          end
          if (result_bus.source_class !== want.src_cls) begin
            $error("source_class: expected %0d, actual %0d", want.src_cls,
                   result_bus.source_class);
            mismatch_count++;
          end
          if (result_bus.result_class !== want.res_cls) begin
            $error("result_class: expected %0d, actual %0d", want.res_cls,
                   result_bus.result_class);
            mismatch_count++;
          end
        end
      end
      if (operand_bus.valid && operand_bus.ready) begin
        pending_conversions.push_back(narrow_to_fp32(operand_bus.sign_bit,
                                                     operand_bus.exponent_field,
                                                     operand_bus.fraction_field));
      end
    end
  end

  // result ready: long hold-off on request, otherwise a changing stall pattern
  initial begin
    rx_pattern_e pattern;
    int unsigned pattern_left;
    int unsigned period;
    int unsigned phase;
    pattern_left = 0;
    period       = 3;
    phase        = 0;
    pattern      = RX_ALWAYS;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        result_bus.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (pattern_left == 0) begin
          pattern      = rx_pattern_e'($urandom_range(0, 2));
          pattern_left = $urandom_range(20, 200);
          period       = $urandom_range(2, 5);
        end
        pattern_left--;
        phase++;
        case (pattern)
          RX_ALWAYS:   result_bus.ready <= 1'b1;
          RX_RANDOM:   result_bus.ready <= ($urandom_range(0, 2) != 0);
          RX_PERIODIC: result_bus.ready <= ((phase % period) != 0);
          default:     result_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  // offer one operand beat, with bursts and random gaps, and wait until taken
  task automatic send_operand(input logic sgn, input logic [31:0] ex, input logic [30:0] fr);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        operand_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    operand_bus.valid          <= 1'b1;
    operand_bus.sign_bit       <= sgn;
    operand_bus.exponent_field <= ex;
    operand_bus.fraction_field <= fr;
    do @(posedge clk); while (!operand_bus.ready);
  endtask

  // zeros, subnormal sources, infinities and nan payloads
  task automatic test_special_values();
    send_operand(1'b0, SRC_EXP_ZERO, 31'd0);
    send_operand(1'b1, SRC_EXP_ZERO, 31'd0);
    send_operand(1'b0, SRC_EXP_ZERO, 31'd1);
    send_operand(1'b1, SRC_EXP_ZERO, 31'h7FFF_FFFF);
    send_operand(1'b0, SRC_EXP_ALL_ONES, 31'd0);
    send_operand(1'b1, SRC_EXP_ALL_ONES, 31'd0);
    // nan whose kept payload would be zero
    send_operand(1'b0, SRC_EXP_ALL_ONES, 31'd1);
    send_operand(1'b1, SRC_EXP_ALL_ONES, 31'h0000_00FF);
    send_operand(1'b0, SRC_EXP_ALL_ONES, 31'h0000_0100);
    send_operand(1'b1, SRC_EXP_ALL_ONES, 31'h7FFF_FFFF);
  endtask

  // normal range, exact and rounded, with carry into the exponent
  task automatic test_normal_range();
    send_operand(1'b0, src_exp(0), 31'd0);
    send_operand(1'b1, src_exp(0), 31'h7FFF_FFFF);
    send_operand(1'b0, NORM_EXP_MIN, 31'd0);
    send_operand(1'b1, src_exp(1), 31'h0000_0080);
    send_operand(1'b0, src_exp(127), 31'h7FFF_FF00);
  endtask

  // too-large exponents and rounding carry out of the top exponent
  task automatic test_overflow();
    send_operand(1'b0, src_exp(127), 31'h7FFF_FFFF);
    send_operand(1'b1, OVF_EXP_MIN, 31'd0);
    send_operand(1'b0, 32'hFFFF_FFFE, 31'h1234_5678);
  endtask

  // subnormal results, carry to the smallest normal, shifts past the word
  task automatic test_underflow();
    send_operand(1'b0, src_exp(-127), 31'd0);
    send_operand(1'b1, src_exp(-127), 31'h7FFF_FFFF);
    send_operand(1'b0, src_exp(-149), 31'd0);
    send_operand(1'b1, src_exp(-149), 31'd5);
    send_operand(1'b0, src_exp(-150), 31'd0);
    send_operand(1'b1, 32'd1, 31'h5555_5555);
  endtask

  // receiver holds off for a long stretch while operands keep coming
  task automatic test_backpressure();
    hold_off_cycles = HOLD_CYCLES;
    repeat (40) begin
      send_operand(1'($urandom), src_exp($urandom_range(0, 253) - 126), 31'($urandom));
    end
  endtask

  // random operands weighted toward the interesting exponent ranges
  task automatic test_random_mix();
    logic        sgn;
    logic [31:0] ex;
    logic [30:0] fr;
    int unsigned pick;
    repeat (RANDOM_ITEMS) begin
      sgn = 1'($urandom);
      case ($urandom_range(0, 4))
        0:       fr = 31'($urandom);
        1:       fr = {23'($urandom), 8'h00};
        2:       fr = '1;
        3:       fr = 31'($urandom_range(0, 255));
        default: fr = 31'd1 << $urandom_range(0, 30);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        ex = SRC_EXP_ZERO;
        if ($urandom_range(0, 3) == 0) fr = '0;
      end else if (pick < 16) begin
        ex = SRC_EXP_ALL_ONES;
        if ($urandom_range(0, 3) == 0) fr = '0;
      end else if (pick < 30) begin
        ex = $urandom;
      end else if (pick < 75) begin
        ex = src_exp($urandom_range(0, 253) - 126);
      end else if (pick < 90) begin
        ex = src_exp(-127 - int'($urandom_range(0, 33)));
      end else begin
        ex = src_exp(125 + int'($urandom_range(0, 5)));
      end
      send_operand(sgn, ex, fr);
    end
  endtask

  // main sequence
  initial begin
    rst                        = 1'b1;
    operand_bus.valid          = 1'b0;
    operand_bus.sign_bit       = 1'b0;
    operand_bus.exponent_field = '0;
    operand_bus.fraction_field = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_special_values();
    test_normal_range();
    test_overflow();
    test_underflow();
    test_backpressure();
    test_random_mix();

    @(negedge clk);
    operand_bus.valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("wide_float_to_fp32_convert_core regression: pass");
    end else begin
      $display("wide_float_to_fp32_convert_core regression: fail");
    end
    $finish;
  end

endmodule
